/* hw/rtl/sstf_request_scheduler_unit_defines.svh */
// Assertion macros for the request scheduler.
`ifndef SSTF_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
`define SSTF_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle.
`define SSTF_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SSTF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

/* hw/rtl/sstf_pkg.sv */
// Shared types and constants of the request scheduler.
package sstf_pkg;
   localparam logic MODE_ADD      = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;
   localparam int   COUNT_BITS    = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_OUTPUT
   } eng_state_type;
endpackage

/* hw/rtl/sstf_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module sstf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/sstf_front.sv */
// Front end: accept requests into a two-entry queue.
module sstf_front #(
   parameter int SECTOR_BITS = 48,
   parameter int TAG_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [SECTOR_BITS-1:0] req_request_sector,
   input  logic [TAG_BITS-1:0]    req_request_tag,
   output logic                   q_valid,
   input  logic                   q_pop,
   output logic                   q_mode,
   output logic [SECTOR_BITS-1:0] q_sector,
   output logic [TAG_BITS-1:0]    q_tag
);
   localparam int ITEM_BITS = 1 + SECTOR_BITS + TAG_BITS;

   logic [ITEM_BITS-1:0] slot_ff [2];
   logic [1:0]           count_ff, count_in;
   logic                 rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic                 push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign {q_mode, q_sector, q_tag} = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= {req_mode, req_request_sector, req_request_tag};
      end
   end
endmodule

/* hw/rtl/sstf_engine.sv */
// Back end: table of pending requests, nearest-sector scan and result register.
`include "sstf_request_scheduler_unit_defines.svh"
module sstf_engine import sstf_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int SECTOR_BITS = 48,
   parameter int TAG_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  logic                   q_mode,
   input  logic [SECTOR_BITS-1:0] q_sector,
   input  logic [TAG_BITS-1:0]    q_tag,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_dispatched,
   output logic [SECTOR_BITS-1:0] rsp_dispatched_sector,
   output logic [TAG_BITS-1:0]    rsp_dispatched_tag,
   output logic                   rsp_add_rejected,
   output logic [COUNT_BITS-1:0]  rsp_pending_count
);
   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_BITS = SECTOR_BITS + TAG_BITS;

   eng_state_type state_ff, state_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_BITS-1:0]    order_ff [QUEUE_DEPTH];
   logic [OCC_BITS-1:0]    occ_ff, occ_in;
   logic [SECTOR_BITS-1:0] head_ff, head_in;
   logic [OCC_BITS-1:0]    scan_ff, scan_in;
   logic [IDX_BITS-1:0]    rd_idx_ff;
   logic                   rd_live_ff;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    best_ff, best_in;
   logic [SECTOR_BITS-1:0] best_dist_ff, best_dist_in;
   logic [ENT_BITS-1:0]    best_ent_ff, best_ent_in;
   logic                   out_disp_ff, out_rej_ff;
   logic [SECTOR_BITS-1:0] out_sec_ff;
   logic [TAG_BITS-1:0]    out_tag_ff;
   logic [COUNT_BITS-1:0]  out_cnt_ff;
   logic                   ram_wr;
   logic [IDX_BITS-1:0]    free_idx;
   logic                   free_found;
   logic [ENT_BITS-1:0]    rd_ent;
   logic [SECTOR_BITS-1:0] rd_sec, seek_dist;
   logic                   better;
   logic                   do_add, rejected, finish_disp;

   sstf_ram #(.WIDTH(ENT_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (free_idx),
      .wr_data ({q_sector, q_tag}),
      .rd_addr (scan_ff[IDX_BITS-1:0]),
      .rd_data (rd_ent)
   );

   // Lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IDX_BITS'(i);
            free_found = 1'b1;
         end
      end
   end

   assign do_add   = (state_ff == ST_IDLE) && q_valid && (q_mode == MODE_ADD) && !rsp_valid;
   assign rejected = !free_found;
   assign ram_wr   = do_add && !rejected;

   // Shared distance and compare unit on the registered read
   assign rd_sec    = rd_ent[ENT_BITS-1:TAG_BITS];
   assign seek_dist = (rd_sec >= head_ff) ? rd_sec - head_ff : head_ff - rd_sec;
   assign better    = !found_ff || (seek_dist < best_dist_ff) ||
                      ((seek_dist == best_dist_ff) &&
                       (order_ff[rd_idx_ff] < order_ff[best_ff]));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid) begin
               state_in = (q_mode == MODE_ADD) ? ST_OUTPUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == OCC_BITS'(QUEUE_DEPTH)) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Scan bookkeeping and table update
   always_comb begin
      scan_in      = scan_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      best_ent_in  = best_ent_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      head_in      = head_ff;
      finish_disp  = 1'b0;
      if (state_ff == ST_IDLE) begin
         scan_in  = '0;
         found_in = 1'b0;
      end
      if (state_ff == ST_SCAN && scan_ff != OCC_BITS'(QUEUE_DEPTH)) begin
         scan_in = scan_ff + 1'b1;
      end
      if ((state_ff == ST_SCAN || state_ff == ST_FINISH) && rd_live_ff &&
          valid_ff[rd_idx_ff] && better) begin
         found_in     = 1'b1;
         best_in      = rd_idx_ff;
         best_dist_in = seek_dist;
         best_ent_in  = rd_ent;
      end
      if (ram_wr) begin
         valid_in[free_idx] = 1'b1;
         occ_in             = occ_ff + 1'b1;
      end
      if (state_ff == ST_OUTPUT && found_ff && q_mode == MODE_DISPATCH) begin
         finish_disp       = 1'b1;
         valid_in[best_ff] = 1'b0;
         occ_in            = occ_ff - 1'b1;
         head_in           = best_ent_ff[ENT_BITS-1:TAG_BITS];
      end
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop = (state_ff == ST_OUTPUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         occ_ff     <= '0;
         head_ff    <= '0;
         rd_live_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         occ_ff     <= occ_in;
         head_ff    <= head_in;
         rd_live_ff <= (state_ff == ST_SCAN) && (scan_ff != OCC_BITS'(QUEUE_DEPTH));
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      rd_idx_ff    <= scan_ff[IDX_BITS-1:0];
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      best_ent_ff  <= best_ent_in;
   end

   // Arrival ranks: newest gets occupancy, removal closes the gap
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (ram_wr && free_idx == IDX_BITS'(i)) begin
            order_ff[i] <= occ_ff[IDX_BITS-1:0];
         end else if (finish_disp && order_ff[i] > order_ff[best_ff]) begin
            order_ff[i] <= order_ff[i] - 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (state_ff == ST_OUTPUT) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         out_disp_ff <= 1'b0;
         out_sec_ff  <= '0;
         out_tag_ff  <= '0;
         out_rej_ff  <= rejected;
      end else if (state_ff == ST_OUTPUT && q_mode == MODE_DISPATCH) begin
         out_disp_ff <= found_ff;
         out_sec_ff  <= found_ff ? best_ent_ff[ENT_BITS-1:TAG_BITS] : '0;
         out_tag_ff  <= found_ff ? best_ent_ff[TAG_BITS-1:0] : '0;
         out_rej_ff  <= 1'b0;
      end
      if (state_ff == ST_OUTPUT) out_cnt_ff <= COUNT_BITS'(occ_in);
   end

   assign rsp_dispatched        = out_disp_ff;
   assign rsp_dispatched_sector = out_sec_ff;
   assign rsp_dispatched_tag    = out_tag_ff;
   assign rsp_add_rejected      = out_rej_ff;
   assign rsp_pending_count     = out_cnt_ff;

   `SSTF_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_BITS'(QUEUE_DEPTH),
      "occupancy above table depth")
   `SSTF_ASSERT_IMPL(a_occ_match, clock, reset, 1'b1,
      OCC_BITS'($countones(valid_ff)) == occ_ff, "occupancy differs from valid bits")
   `SSTF_ASSERT_NEXT(a_pop_resp, clock, reset, q_pop, rsp_valid,
      "request retired without a response")
endmodule

/* hw/rtl/sstf_request_scheduler_unit.sv */
// Top level of the shortest-seek-first request scheduler.
// Requests enter a two-entry queue and a sequencer serves them one at a time.
// An add passes from the queue head through the IDLE and OUTPUT states to the
// response register; a dispatch passes through IDLE, SCAN, FINISH and OUTPUT,
// and its scan reads one table entry per cycle through the single RAM read port
// into one shared subtract and compare unit. No clearing pass after reset.
module sstf_request_scheduler_unit import sstf_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int SECTOR_BITS = 48,
   parameter int TAG_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [SECTOR_BITS-1:0] req_request_sector,
   input  logic [TAG_BITS-1:0]    req_request_tag,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_dispatched,
   output logic [SECTOR_BITS-1:0] rsp_dispatched_sector,
   output logic [TAG_BITS-1:0]    rsp_dispatched_tag,
   output logic                   rsp_add_rejected,
   output logic [COUNT_BITS-1:0]  rsp_pending_count
);
   logic                   q_valid, q_pop, q_mode;
   logic [SECTOR_BITS-1:0] q_sector;
   logic [TAG_BITS-1:0]    q_tag;

   sstf_front #(.SECTOR_BITS(SECTOR_BITS), .TAG_BITS(TAG_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_request_sector,
      .req_request_tag, .q_valid, .q_pop, .q_mode, .q_sector, .q_tag
   );

   sstf_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .SECTOR_BITS(SECTOR_BITS),
                 .TAG_BITS(TAG_BITS)) u_engine (
      .clock, .reset, .q_valid, .q_pop, .q_mode, .q_sector, .q_tag,
      .rsp_valid, .rsp_ready, .rsp_dispatched, .rsp_dispatched_sector,
      .rsp_dispatched_tag, .rsp_add_rejected, .rsp_pending_count
   );
endmodule
